@@ hdl/fena_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fena_pkg
// Shared types and constants of the fire-effect neighbor average block.
// ----------------------------------------------------------------------------
package fena_pkg;

   // field widths of the pixel stream and the register port
   localparam int PIXEL_W = 16;
   localparam int COORD_W = 8;
   localparam int CFG_W   = 9;
   localparam int DATA_W  = 32;
   localparam int ADDR_W  = 3;

   // register map, indexed by the word address
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   // register reset values
   localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 9'd80;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 9'd64;

   // smallest legal frame dimension
   localparam logic [CFG_W-1:0] MIN_DIM = 9'd3;

   // result beat sequence of one item
   typedef enum logic [1:0] {
      BEAT_VALUE,
      BEAT_ZERO_UPPER,
      BEAT_ZERO_LOWER
   } beat_type;

   // one item leaving the compute stage for the output register
   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               bottom_rows;
      logic [COORD_W-1:0] bottom_first_row;
   } result_entry_type;

endpackage

@@ hdl/fena_channels.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fena_channels
// Valid/ready stream interfaces for the pixel input and the result output.
// ----------------------------------------------------------------------------
interface fena_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] pixel_in;
   logic        frame_start;

   modport source (output valid, output pixel_in, output frame_start, input ready);
   modport sink   (input valid, input pixel_in, input frame_start, output ready);
endinterface

interface fena_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] pixel_out;
   logic [7:0]  out_row;
   logic [7:0]  out_col;
   logic        run_last;

   modport source (output valid, output pixel_out, output out_row, output out_col,
                   output run_last, input ready);
   modport sink   (input valid, input pixel_out, input out_row, input out_col,
                   input run_last, output ready);
endinterface

@@ hdl/fena_csr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fena_csr
// APB-style register file holding the frame geometry, with clamped outputs.
// ----------------------------------------------------------------------------
module fena_csr
   import fena_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   localparam int WD_W = $clog2(MAX_WIDTH + 1),
   localparam int HD_W = $clog2(MAX_HEIGHT + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output logic [WD_W-1:0]   width_eff,
   output logic [HD_W-1:0]   height_eff
);

   localparam int WC_W = (WD_W > CFG_W) ? WD_W : CFG_W;
   localparam int HC_W = (HD_W > CFG_W) ? HD_W : CFG_W;

   logic [CFG_W-1:0] frame_width_ff, frame_width_in;
   logic [CFG_W-1:0] frame_height_ff, frame_height_in;
   logic             wr_fire;
   logic             reg_index;
   logic [WC_W-1:0]  width_ext;
   logic [HC_W-1:0]  height_ext;

   assign pready    = 1'b1;
   assign wr_fire   = psel && penable && pwrite;
   assign reg_index = paddr[2];

   // register write decode
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (wr_fire) begin
         unique case (reg_index)
            REG_FRAME_WIDTH:  frame_width_in  = pwdata[CFG_W-1:0];
            REG_FRAME_HEIGHT: frame_height_in = pwdata[CFG_W-1:0];
            default:          frame_width_in  = frame_width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   // read mux
   always_comb begin
      unique case (reg_index)
         REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width_ff);
         REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height_ff);
         default:          prdata = '0;
      endcase
   end

   // clamp geometry to the legal range
   assign width_ext  = WC_W'(frame_width_ff);
   assign height_ext = HC_W'(frame_height_ff);

   always_comb begin
      if (frame_width_ff < MIN_DIM) begin
         width_eff = WD_W'(MIN_DIM);
      end else if (width_ext > WC_W'(MAX_WIDTH)) begin
         width_eff = WD_W'(MAX_WIDTH);
      end else begin
         width_eff = WD_W'(width_ext);
      end
      if (frame_height_ff < MIN_DIM) begin
         height_eff = HD_W'(MIN_DIM);
      end else if (height_ext > HC_W'(MAX_HEIGHT)) begin
         height_eff = HD_W'(MAX_HEIGHT);
      end else begin
         height_eff = HD_W'(height_ext);
      end
   end

endmodule

@@ hdl/fena_line_buffer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fena_line_buffer
// One-row pixel memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module fena_line_buffer
   import fena_pkg::*;
#(
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               access,
   input  logic [AW-1:0]      wr_addr,
   input  logic [PIXEL_W-1:0] wr_data,
   input  logic [AW-1:0]      rd_addr_a,
   input  logic [AW-1:0]      rd_addr_b,
   output logic [PIXEL_W-1:0] rd_data_a_ff,
   output logic [PIXEL_W-1:0] rd_data_b_ff
);

   logic [PIXEL_W-1:0] mem [DEPTH];

   // reads see the contents from before this transfer's write
   always_ff @(posedge clock) begin
      if (access) begin
         rd_data_a_ff <= mem[rd_addr_a];
         rd_data_b_ff <= mem[rd_addr_b];
         mem[wr_addr] <= wr_data;
      end
   end

endmodule

@@ hdl/fena_result_out.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fena_result_out
// Output register; on the last row it appends the two zero bottom-row beats.
// ----------------------------------------------------------------------------
module fena_result_out
   import fena_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  result_entry_type  entry,
   output logic              free,
   fena_rsp_if.source        rsp_bus
);

   beat_type             beat_ff, beat_in;
   logic                 valid_ff, valid_in;
   logic [PIXEL_W-1:0]   pixel_ff, pixel_in;
   logic [COORD_W-1:0]   row_ff, row_in;
   logic [COORD_W-1:0]   col_ff;
   logic [COORD_W-1:0]   bottom_row_ff;
   logic                 bottom_ff;
   logic                 last_beat;
   logic                 take;

   assign take = valid_ff && rsp_bus.ready;
   assign free = !valid_ff || (rsp_bus.ready && last_beat);

   // next beat
   always_comb begin
      beat_in = beat_ff;
      if (load) begin
         beat_in = BEAT_VALUE;
      end else if (take && !last_beat) begin
         unique case (beat_ff)
            BEAT_VALUE:      beat_in = BEAT_ZERO_UPPER;
            BEAT_ZERO_UPPER: beat_in = BEAT_ZERO_LOWER;
            default:         beat_in = BEAT_VALUE;
         endcase
      end
   end

   // beat outputs
   always_comb begin
      unique case (beat_ff)
         BEAT_VALUE:      last_beat = !bottom_ff;
         BEAT_ZERO_UPPER: last_beat = 1'b0;
         BEAT_ZERO_LOWER: last_beat = 1'b1;
         default:         last_beat = 1'b1;
      endcase
   end

   // payload of the following beat
   always_comb begin
      valid_in = valid_ff;
      pixel_in = pixel_ff;
      row_in   = row_ff;
      if (load) begin
         valid_in = 1'b1;
         pixel_in = entry.pixel;
         row_in   = entry.row;
      end else if (take) begin
         if (last_beat) begin
            valid_in = 1'b0;
         end else begin
            pixel_in = '0;
            row_in   = (beat_ff == BEAT_VALUE) ? bottom_row_ff : row_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= BEAT_VALUE;
      end else begin
         valid_ff <= valid_in;
         beat_ff  <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      pixel_ff <= pixel_in;
      row_ff   <= row_in;
      if (load) begin
         col_ff        <= entry.col;
         bottom_ff     <= entry.bottom_rows;
         bottom_row_ff <= entry.bottom_first_row;
      end
   end

   assign rsp_bus.valid     = valid_ff;
   assign rsp_bus.pixel_out = pixel_ff;
   assign rsp_bus.out_row   = row_ff;
   assign rsp_bus.out_col   = col_ff;
   assign rsp_bus.run_last  = last_beat;

endmodule

@@ hdl/fire_effect_neighbor_average.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fire_effect_neighbor_average
// Streaming fire-effect filter: four-neighbor average of old pixels.
// ----------------------------------------------------------------------------
// Pixels of a frame enter on req_bus in raster order, one transfer each, with
// frame_start on the first one. Results leave on rsp_bus two rows behind the
// input, each tagged with its row and column; run_last marks the final result
// of one input transfer. Interior pixels get the average of the pixel two rows
// below and the three pixels one row below it; edge columns keep their
// old value and the two bottom rows come out as zero.
// Throughput: one pixel per cycle while rsp_bus is ready. Each pixel of the
// last row yields three results, so that row holds the input while they leave.
// An input transfer is captured by the line-buffer read and the compute stage
// register; the compute stage then loads its result into the output register,
// holding while that register is still occupied.
// The user must write the frame geometry over the psel/penable port only while
// idle; the block does not enforce this. Reset clears counters, edge holds and
// valid flags; the line buffer is not cleared, the first two rows write it
// before it is read. When rsp_bus stalls the output register and the compute
// stage hold and req_bus.ready drops once both are full; nothing is dropped.
// ----------------------------------------------------------------------------
module fire_effect_neighbor_average
   import fena_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic              clock,
   input  logic              reset,
   fena_req_if.sink          req_bus,
   fena_rsp_if.source        rsp_bus,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int RW   = $clog2(MAX_HEIGHT);
   localparam int WD_W = $clog2(MAX_WIDTH + 1);
   localparam int HD_W = $clog2(MAX_HEIGHT + 1);
   localparam int SUM_W = PIXEL_W + 2;

   logic [WD_W-1:0] width_eff;
   logic [HD_W-1:0] height_eff;

   // geometry registers
   fena_csr #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .width_eff (width_eff),
      .height_eff(height_eff)
   );

   // position counters, advanced on each input transfer
   logic [CW-1:0]   col_ff, col_in;
   logic [RW-1:0]   row_ff, row_in;
   logic [CW-1:0]   col_cur;
   logic [RW-1:0]   row_cur;
   logic [WD_W-1:0] col_cur_next;
   logic [HD_W-1:0] row_cur_next;
   logic [CW:0]     col_plus;
   logic [CW-1:0]   addr_right;
   logic            right_off_end;
   logic            accept;

   assign accept        = req_bus.valid && req_bus.ready;
   assign col_cur       = req_bus.frame_start ? '0 : col_ff;
   assign row_cur       = req_bus.frame_start ? '0 : row_ff;
   assign col_cur_next  = WD_W'(col_cur) + 1'b1;
   assign row_cur_next  = HD_W'(row_cur) + 1'b1;
   assign col_plus      = {1'b0, col_cur} + 1'b1;
   assign right_off_end = (col_cur == CW'(MAX_WIDTH - 1));
   assign addr_right    = right_off_end ? '0 : col_plus[CW-1:0];

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_cur_next >= width_eff) begin
            col_in = '0;
            row_in = (row_cur_next >= height_eff) ? '0 : RW'(row_cur_next);
         end else begin
            col_in = col_plus[CW-1:0];
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line buffer holding the previous input row
   logic [PIXEL_W-1:0] up_center;
   logic [PIXEL_W-1:0] up_right_raw;

   fena_line_buffer #(
      .DEPTH(MAX_WIDTH)
   ) u_line (
      .clock       (clock),
      .access      (accept),
      .wr_addr     (col_cur),
      .wr_data     (req_bus.pixel_in),
      .rd_addr_a   (col_cur),
      .rd_addr_b   (addr_right),
      .rd_data_a_ff(up_center),
      .rd_data_b_ff(up_right_raw)
   );

   // compute stage register
   logic               s1_valid_ff, s1_valid_in;
   logic [PIXEL_W-1:0] s1_pixel_ff;
   logic [CW-1:0]      s1_col_ff;
   logic [RW-1:0]      s1_row_ff;
   logic               s1_right_zero_ff;
   logic               s1_advance;
   logic               s1_emit;
   logic               out_free;
   logic               out_load;

   assign s1_emit     = s1_row_ff >= RW'(2);
   assign s1_advance  = s1_valid_ff && (!s1_emit || out_free);
   assign req_bus.ready = !s1_valid_ff || s1_advance;
   assign out_load    = s1_advance && s1_emit;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff      <= req_bus.pixel_in;
         s1_col_ff        <= col_cur;
         s1_row_ff        <= row_cur;
         s1_right_zero_ff <= right_off_end;
      end
   end

   // neighbor state: row-above value of the previous column and edge pixels
   logic [PIXEL_W-1:0] left_ff;
   logic [PIXEL_W-1:0] edge_ff [4];
   logic [1:0]         edge_idx;
   logic               is_edge;
   logic [PIXEL_W-1:0] up_right;
   logic [HD_W:0]      row_plus2;
   logic [HD_W-1:0]    row_plus1;
   logic [SUM_W-1:0]   sum_below;
   logic [SUM_W-1:0]   sum_total;
   logic [PIXEL_W-1:0] value;

   assign up_right  = s1_right_zero_ff ? '0 : up_right_raw;
   assign is_edge   = (s1_col_ff == '0) || ((WD_W'(s1_col_ff) + 1'b1) >= width_eff);
   assign edge_idx  = {s1_row_ff[0], (s1_col_ff != '0)};
   assign row_plus2 = (HD_W + 1)'(s1_row_ff) + 2'd2;
   assign row_plus1 = HD_W'(s1_row_ff) + 1'b1;

   // four-neighbor sum, rows beyond the bottom read as zero
   always_comb begin
      sum_below = '0;
      sum_total = '0;
      if (row_plus1 < height_eff) begin
         sum_below = SUM_W'(left_ff) + SUM_W'(up_center) + SUM_W'(up_right);
      end
      if (row_plus2 < (HD_W + 1)'(height_eff)) begin
         sum_total = sum_below + SUM_W'(s1_pixel_ff);
      end else begin
         sum_total = sum_below;
      end
      value = is_edge ? edge_ff[edge_idx] : sum_total[SUM_W-1:2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         for (int i = 0; i < 4; i++) begin
            edge_ff[i] <= '0;
         end
      end else if (s1_advance) begin
         left_ff <= up_center;
         if (is_edge) begin
            edge_ff[edge_idx] <= s1_pixel_ff;
         end
      end
   end

   // output register with bottom-row zero beats
   result_entry_type entry;

   assign entry.pixel            = value;
   assign entry.row              = COORD_W'(s1_row_ff - RW'(2));
   assign entry.col              = COORD_W'(s1_col_ff);
   assign entry.bottom_rows      = (row_plus1 == height_eff);
   assign entry.bottom_first_row = COORD_W'(height_eff - HD_W'(2));

   fena_result_out u_out (
      .clock  (clock),
      .reset  (reset),
      .load   (out_load),
      .entry  (entry),
      .free   (out_free),
      .rsp_bus(rsp_bus)
   );

   // compute stage only holds while the output register is occupied
   a_stall_needs_output: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |-> rsp_bus.valid)
      else $error("compute stage stalled with an empty output register");

   // frame start restarts the position at the origin
   a_frame_start_origin: assert property (@(posedge clock) disable iff (reset)
      (accept && req_bus.frame_start) |=> (s1_row_ff == '0 && s1_col_ff == '0))
      else $error("frame start did not reset the position");

   // an item is only loaded when the output register can take it
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("output register overwritten");

   // a transfer into the compute stage leaves it valid
   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted item lost before the compute stage");

endmodule

@@ bench/fena_heat_check_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fena_heat_check_pkg
// Scoreboard of the fire-effect neighbor average bench: it follows the pixel
// stream with its own copy of the line buffer, the edge holds and the
// row/column counters, queues the heat values each input transfer should
// produce and checks the results in order as they leave the block.
// ----------------------------------------------------------------------------
package fena_heat_check_pkg;
   import fena_pkg::*;

   localparam int LINE_DEPTH = 256;
   localparam int DIM_LIMIT  = 256;

   // one result as it leaves the block
   typedef struct packed {
      logic [PIXEL_W-1:0] heat;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               last;
   } heat_result_type;

   class fire_heat_scoreboard;
      logic [CFG_W-1:0]   width_reg;
      logic [CFG_W-1:0]   height_reg;
      logic [PIXEL_W-1:0] line_store [LINE_DEPTH];
      logic [PIXEL_W-1:0] up_hold [2];
      logic [PIXEL_W-1:0] edge_hold [4];
      logic [COORD_W-1:0] row_pos;
      logic [COORD_W-1:0] col_pos;
      heat_result_type    pending_heat [$];
      int unsigned        error_count;

      function new();
         width_reg   = FRAME_WIDTH_RESET;
         height_reg  = FRAME_HEIGHT_RESET;
         foreach (line_store[i]) line_store[i] = '0;
         foreach (up_hold[i]) up_hold[i] = '0;
         foreach (edge_hold[i]) edge_hold[i] = '0;
         row_pos     = '0;
         col_pos     = '0;
         error_count = 0;
      endfunction

      // frame geometry as the block uses it
      static function int unsigned clamp_dim(logic [CFG_W-1:0] value);
         if (value < MIN_DIM) return MIN_DIM;
         if (value > DIM_LIMIT) return DIM_LIMIT;
         return value;
      endfunction

      function void write_geometry(logic index, logic [CFG_W-1:0] value);
         if (index == REG_FRAME_WIDTH) width_reg = value;
         else height_reg = value;
      endfunction

      // one accepted pixel: queue the results of its lagged position
      function void average_neighbors(logic [PIXEL_W-1:0] pixel, logic frame_start);
         int unsigned  w, h, r, c, slot, heat, sum, n, k;
         logic [PIXEL_W-1:0] up_c, up_r, left;
         heat_result_type outs [3];
         if (frame_start) begin
            row_pos = '0;
            col_pos = '0;
         end
         w = clamp_dim(width_reg);
         h = clamp_dim(height_reg);
         r = row_pos;
         c = col_pos;

         // row above at c and c+1, row above at c-1 from the previous transfer
         up_c = line_store[c];
         up_r = (c + 1 < LINE_DEPTH) ? line_store[c + 1] : '0;
         up_hold[1] = up_c;
         left = up_hold[0];

         // edge columns keep the value seen two rows earlier
         slot = (r % 2) * 2 + ((c == 0) ? 0 : 1);
         if (c == 0 || c + 1 >= w) begin
            heat = edge_hold[slot];
         end else begin
            sum = 0;
            if (r + 2 < h) sum += pixel;
            if (r + 1 < h) sum += left + up_c + up_r;
            heat = sum >> 2;
         end

         // lagged result, plus the two zero bottom rows on the last row
         n = 0;
         if (r >= 2) begin
            outs[0] = '{PIXEL_W'(heat), COORD_W'(r - 2), COORD_W'(c), 1'b0};
            n = 1;
            if (r == h - 1) begin
               outs[1] = '{'0, COORD_W'(h - 2), COORD_W'(c), 1'b0};
               outs[2] = '{'0, COORD_W'(h - 1), COORD_W'(c), 1'b0};
               n = 3;
            end
         end
         for (k = 0; k < n; k++) begin
            outs[k].last = (k == n - 1);
            pending_heat.push_back(outs[k]);
         end

         if (c == 0 || c + 1 >= w) edge_hold[slot] = pixel;
         up_hold[0] = up_hold[1];
         line_store[c] = pixel;

         // advance position, the row counter wraps after the last row
         if (c + 1 >= w) begin
            col_pos = '0;
            row_pos = (r + 1 >= h) ? '0 : COORD_W'(r + 1);
         end else begin
            col_pos = COORD_W'(c + 1);
         end
      endfunction

      task report_mismatch(string what);
         error_count++;
         if (error_count <= 40) $display("mismatch: %s", what);
      endtask

      task check_result(heat_result_type got);
         heat_result_type want;
         if (pending_heat.size() == 0) begin
            report_mismatch($sformatf("unexpected result heat %h at (%0d,%0d)",
                                      got.heat, got.row, got.col));
            return;
         end
         want = pending_heat.pop_front();
         if (got.heat !== want.heat)
            report_mismatch($sformatf("heat %h, wanted %h at (%0d,%0d)",
                                      got.heat, want.heat, want.row, want.col));
         if (got.row !== want.row)
            report_mismatch($sformatf("row %0d, wanted %0d", got.row, want.row));
         if (got.col !== want.col)
            report_mismatch($sformatf("col %0d, wanted %0d at row %0d",
                                      got.col, want.col, want.row));
         if (got.last !== want.last)
            report_mismatch($sformatf("run_last %b, wanted %b at (%0d,%0d)",
                                      got.last, want.last, want.row, want.col));
      endtask
   endclass

endpackage

@@ bench/fire_effect_neighbor_average_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fire_effect_neighbor_average_test
// Drives pixel frames of many geometries through the fire-effect filter while
// both stream sides idle at random, and checks every result in order against
// the scoreboard's prediction. Geometry is changed over the register port
// between phases, with out-of-range values and a mid-frame shrink included.
// ----------------------------------------------------------------------------
module fire_effect_neighbor_average_test;
   import fena_pkg::*;
   import fena_heat_check_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 20000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned RANDOM_ITEMS = 32;

   typedef enum {STALL_NONE, STALL_COIN, STALL_PATTERN, STALL_SPARSE} stall_mode_type;
   typedef enum {FRAME_CLEAN, FRAME_RUN_ON, FRAME_CUT, FRAME_STRAY_START} frame_kind_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   fena_req_if req_bus ();
   fena_rsp_if rsp_bus ();

   fire_heat_scoreboard board;
   int unsigned         cycle_count = 0;
   int unsigned         burst_left = 0;
   int unsigned         sent_items = 0;
   int unsigned         frame_w = 80;
   int unsigned         frame_h = 64;

   fire_effect_neighbor_average #(
      .MAX_WIDTH  (256),
      .MAX_HEIGHT (256)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #1 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // transfers on both channels; results are checked before the new pixel is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready)
            board.check_result(heat_result_type'{rsp_bus.pixel_out, rsp_bus.out_row,
                                                 rsp_bus.out_col, rsp_bus.run_last});
         if (req_bus.valid && req_bus.ready)
            board.average_neighbors(req_bus.pixel_in, req_bus.frame_start);
      end
   end

   // receiver: stretches of one stall mode after another
   initial begin : receiver
      stall_mode_type mode;
      int unsigned span;
      int unsigned phase_bit;
      logic [31:0] pattern;
      rsp_bus.ready = 1'b0;
      phase_bit = 0;
      forever begin
         mode    = stall_mode_type'($urandom_range(0, 3));
         span    = $urandom_range(24, 160);
         pattern = $urandom | $urandom | 32'h1;
         repeat (span) begin
            @(negedge clock);
            case (mode)
               STALL_NONE: rsp_bus.ready <= 1'b1;
               STALL_COIN: rsp_bus.ready <= 1'($urandom_range(0, 1));
               STALL_PATTERN: begin
                  rsp_bus.ready <= pattern[phase_bit];
                  phase_bit = (phase_bit + 1) % 32;
               end
               default: rsp_bus.ready <= ($urandom_range(0, 5) != 0);
            endcase
         end
      end
   end

   function automatic logic [PIXEL_W-1:0] random_heat();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return PIXEL_W'($urandom);
      endcase
   endfunction

   // one pixel transfer, with a random gap at the start of each burst
   task automatic send_pixel(input logic [PIXEL_W-1:0] pixel, input logic start);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 4);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_bus.valid       <= 1'b1;
      req_bus.pixel_in    <= pixel;
      req_bus.frame_start <= start;
      do @(posedge clock); while (!req_bus.ready);
      burst_left--;
      sent_items++;
   endtask

   // sender holds off until every expected result is out and the pipe is empty
   task automatic settle();
      @(negedge clock);
      req_bus.valid       <= 1'b0;
      req_bus.frame_start <= 1'b0;
      while (board.pending_heat.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      burst_left = 0;
   endtask

   task automatic write_reg(input logic index, input logic [CFG_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= DATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      board.write_geometry(index, value);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (index == REG_FRAME_WIDTH) frame_w = fire_heat_scoreboard::clamp_dim(value);
      else frame_h = fire_heat_scoreboard::clamp_dim(value);
   endtask

   // a frame of random heat, well formed or broken in one of a few ways
   task automatic send_frame(input frame_kind_type kind);
      int unsigned total;
      int unsigned stray_at;
      int unsigned k;
      total    = frame_w * frame_h;
      stray_at = $urandom_range(1, total - 1);
      if (kind == FRAME_CUT) total = $urandom_range(1, total - 1);
      else if (kind == FRAME_RUN_ON) total += $urandom_range(1, 2 * frame_w);
      for (k = 0; k < total; k++)
         send_pixel(random_heat(), k == 0 || (kind == FRAME_STRAY_START && k == stray_at));
   endtask

   initial begin : stimulus
      int unsigned i;
      int unsigned random_start;
      int unsigned frames;
      int unsigned pick;
      frame_kind_type kind;

      board               = new();
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.pixel_in    = '0;
      req_bus.frame_start = 1'b0;
      psel                = 1'b0;
      penable             = 1'b0;
      pwrite              = 1'b0;
      paddr               = '0;
      pwdata              = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // 4x4 frame of extreme heats: silent first rows, triple results on the last
      write_reg(REG_FRAME_WIDTH, 9'd4);
      write_reg(REG_FRAME_HEIGHT, 9'd4);
      for (i = 0; i < 16; i++) send_pixel((i % 3 == 0) ? '0 : '1, i == 0);
      // frame runs past its height, the row counter wraps
      for (i = 0; i < 4; i++) send_pixel(random_heat(), 1'b0);
      // frame start in the middle of a row, stale edge and line values stay
      send_pixel('1, 1'b0);
      send_pixel('0, 1'b1);
      send_pixel('1, 1'b0);
      settle();

      // geometry shrinks mid-frame: a row past the last row
      write_reg(REG_FRAME_WIDTH, 9'd6);
      write_reg(REG_FRAME_HEIGHT, 9'd6);
      for (i = 0; i < 20; i++) send_pixel(random_heat(), i == 0);
      settle();
      write_reg(REG_FRAME_WIDTH, 9'd4);
      write_reg(REG_FRAME_HEIGHT, 9'd3);
      for (i = 0; i < 5; i++) send_pixel(random_heat(), 1'b0);
      settle();

      // out-of-range register values clamp to the legal extremes
      write_reg(REG_FRAME_WIDTH, 9'd0);
      write_reg(REG_FRAME_HEIGHT, 9'd2);
      send_frame(FRAME_CLEAN);
      settle();
      // widest row: only the start of the first row
      write_reg(REG_FRAME_WIDTH, 9'd511);
      write_reg(REG_FRAME_HEIGHT, 9'd1);
      for (i = 0; i < 8; i++) send_pixel(random_heat(), i == 0);
      settle();
      // tallest frame: the first four rows
      write_reg(REG_FRAME_WIDTH, 9'd1);
      write_reg(REG_FRAME_HEIGHT, 9'd511);
      for (i = 0; i < 12; i++) send_pixel(random_heat(), i == 0);
      settle();

      // random phases of small frames, mostly well formed
      random_start = sent_items;
      while (sent_items - random_start < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 3);
         if (pick != 1)
            write_reg(REG_FRAME_WIDTH, ($urandom_range(0, 7) == 0) ?
                      CFG_W'($urandom_range(0, 2)) : CFG_W'($urandom_range(3, 8)));
         if (pick != 0)
            write_reg(REG_FRAME_HEIGHT, ($urandom_range(0, 7) == 0) ?
                      CFG_W'($urandom_range(0, 2)) : CFG_W'($urandom_range(3, 5)));
         frames = $urandom_range(1, 2);
         repeat (frames) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) kind = FRAME_CLEAN;
            else if (pick < 8) kind = FRAME_RUN_ON;
            else if (pick == 8) kind = FRAME_CUT;
            else kind = FRAME_STRAY_START;
            send_frame(kind);
         end
         settle();
      end

      if (board.error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/fena_pkg.sv
hdl/fena_channels.sv
hdl/fena_csr.sv
hdl/fena_line_buffer.sv
hdl/fena_result_out.sv
hdl/fire_effect_neighbor_average.sv
bench/fena_heat_check_pkg.sv
bench/fire_effect_neighbor_average_test.sv
